/* design/multi_task_heartbeat_watchdog_defines.svh */
// Assertion macros for the heartbeat watchdog.
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_DEFINES_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_DEFINES_SVH
`ifndef SYNTHESIS
`define MTHW_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define MTHW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define MTHW_ASSERT(lbl, expr, msg)
`define MTHW_ASSERT_IMP(lbl, ante, cons, msg)
`endif
`endif

/* design/mthw_pkg.sv */
`timescale 1ns / 1ps
package mthw_pkg;
  localparam int ID_W         = 32;
  localparam int TICK_W       = 32;
  localparam int CFG_IDX_W    = 1;
  localparam int RESULT_LIMIT = 16;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

  localparam logic [TICK_W-1:0] DEFAULT_PERIOD = 32'd5000;

  localparam logic [1:0] ACT_REGISTER  = 2'd0;
  localparam logic [1:0] ACT_HEARTBEAT = 2'd1;
  localparam logic [1:0] ACT_TICK      = 2'd2;

  localparam logic [1:0] KIND_TIMEOUT = 2'd0;
  localparam logic [1:0] KIND_ALL_OK  = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_INTERVAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT        = 1'd1;

  typedef enum logic [1:0] {
    OP_HB,
    OP_REG,
    OP_CHK
  } tok_op_t;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]      report_kind;
    logic [ID_W-1:0] report_id;
    logic            last_of_run;
  } out_item_t;

  // token walking the cell chain
  typedef struct packed {
    logic              v;
    tok_op_t           op;
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] now;
    logic              done;
    logic              any;
  } tok_t;

  typedef struct packed {
    logic            v;
    logic [ID_W-1:0] id;
  } rep_t;
endpackage

/* design/mthw_cell.sv */
`timescale 1ns / 1ps
module mthw_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic [mthw_pkg::TICK_W-1:0] timeout_ticks,
  input  mthw_pkg::tok_t              tok_in,
  output mthw_pkg::tok_t              tok_out,
  output mthw_pkg::rep_t              rep
);
  import mthw_pkg::*;

  logic              valid_r, valid_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TICK_W-1:0] stamp_r, stamp_nxt;
  tok_t              tok_r, tok_nxt;
  logic              match;
  logic [TICK_W-1:0] age;

  always_comb begin
    match     = valid_r && (id_r == tok_in.id);
    age       = tok_in.now - stamp_r;
    rep.v     = tok_in.v && (tok_in.op == OP_CHK) && valid_r && (age >= timeout_ticks);
    rep.id    = id_r;
    valid_nxt = valid_r;
    id_nxt    = id_r;
    stamp_nxt = stamp_r;
    tok_nxt   = tok_in;
    tok_nxt.any = tok_in.any | valid_r;
    if (tok_in.v && !tok_in.done && (tok_in.op == OP_HB || tok_in.op == OP_REG)) begin
      if (match) begin
        stamp_nxt    = tok_in.now;
        tok_nxt.done = 1'b1;
      end else if (tok_in.op == OP_REG && !valid_r) begin
        valid_nxt    = 1'b1;
        id_nxt       = tok_in.id;
        stamp_nxt    = tok_in.now;
        tok_nxt.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      id_r    <= id_nxt;
      stamp_r <= stamp_nxt;
    end
  end

  assign tok_out = tok_r;
endmodule

/* design/mthw_ctrl.sv */
`timescale 1ns / 1ps
`include "multi_task_heartbeat_watchdog_defines.svh"
module mthw_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mthw_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mthw_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [mthw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mthw_pkg::TICK_W-1:0]    cfg_wdata,
  output mthw_pkg::tok_t                 tok_head,
  input  mthw_pkg::tok_t                 tok_tail,
  input  mthw_pkg::rep_t                 rep,
  output logic                           adv,
  output logic [mthw_pkg::TICK_W-1:0]    timeout_ticks
);
  import mthw_pkg::*;

  logic [TICK_W-1:0] interval_r, interval_nxt;
  logic [TICK_W-1:0] timeout_r, timeout_nxt;
  logic [TICK_W-1:0] now_r, now_nxt;
  logic [TICK_W-1:0] last_chk_r, last_chk_nxt;
  logic              busy_r, busy_nxt;
  tok_t              tok_head_r, tok_head_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [ID_W-1:0]   pend_id_r, pend_id_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_acc, out_free, chk_due, push, fin_need;
  logic [TICK_W-1:0] tick_now;
  out_item_t         push_data, fin_data;

  always_comb begin
    in_acc   = in_valid && !busy_r;
    out_free = !out_valid_r || out_ready;
    tick_now = now_r + TICK_W'(1);
    chk_due  = (tick_now - last_chk_r) >= interval_r;

    interval_nxt  = interval_r;
    timeout_nxt   = timeout_r;
    now_nxt       = now_r;
    last_chk_nxt  = last_chk_r;
    busy_nxt      = busy_r;
    tok_head_nxt  = tok_head_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    adv           = 1'b1;
    push          = 1'b0;
    push_data     = '{report_kind: KIND_TIMEOUT, report_id: pend_id_r, last_of_run: 1'b0};
    fin_need      = 1'b0;
    fin_data      = '{report_kind: KIND_TIMEOUT, report_id: pend_id_r, last_of_run: 1'b1};

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (tok_tail.v) begin
      case (tok_tail.op)
        OP_CHK: begin
          if (pend_v_r) begin
            fin_need = 1'b1;
          end else if (tok_tail.any) begin
            fin_need = 1'b1;
            fin_data = '{report_kind: KIND_ALL_OK, report_id: '0, last_of_run: 1'b1};
          end
        end
        OP_REG: begin
          if (!tok_tail.done) begin
            fin_need = 1'b1;
            fin_data = '{report_kind: KIND_DROPPED, report_id: tok_tail.id,
                         last_of_run: 1'b1};
          end
        end
        default: fin_need = 1'b0;
      endcase
      if (fin_need && !out_free) begin
        adv = 1'b0;
      end else begin
        push       = fin_need;
        push_data  = fin_data;
        busy_nxt   = 1'b0;
        pend_v_nxt = 1'b0;
        cnt_nxt    = '0;
      end
    end else if (rep.v && (cnt_r < CNT_W'(RESULT_LIMIT))) begin
      if (pend_v_r) begin
        if (out_free) begin
          push        = 1'b1;
          pend_id_nxt = rep.id;
          cnt_nxt     = cnt_r + CNT_W'(1);
        end else begin
          adv = 1'b0;
        end
      end else begin
        pend_v_nxt  = 1'b1;
        pend_id_nxt = rep.id;
        cnt_nxt     = cnt_r + CNT_W'(1);
      end
    end

    if (push) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = push_data;
    end

    if (adv) begin
      tok_head_nxt.v = 1'b0;
    end

    if (in_acc) begin
      case (in_data.action)
        ACT_REGISTER: begin
          tok_head_nxt = '{v: 1'b1, op: OP_REG, id: in_data.task_id, now: now_r,
                           done: 1'b0, any: 1'b0};
          busy_nxt     = 1'b1;
        end
        ACT_HEARTBEAT: begin
          tok_head_nxt = '{v: 1'b1, op: OP_HB, id: in_data.task_id, now: now_r,
                           done: 1'b0, any: 1'b0};
          busy_nxt     = 1'b1;
        end
        ACT_TICK: begin
          now_nxt = tick_now;
          if (chk_due) begin
            last_chk_nxt = tick_now;
            tok_head_nxt = '{v: 1'b1, op: OP_CHK, id: in_data.task_id, now: tick_now,
                             done: 1'b0, any: 1'b0};
            busy_nxt     = 1'b1;
          end
        end
        default: busy_nxt = busy_r;
      endcase
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_CHECK_INTERVAL: interval_nxt = cfg_wdata;
        CFG_TIMEOUT:        timeout_nxt  = cfg_wdata;
        default:            interval_nxt = interval_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= DEFAULT_PERIOD;
      timeout_r   <= DEFAULT_PERIOD;
      now_r       <= '0;
      last_chk_r  <= '0;
      busy_r      <= 1'b0;
      tok_head_r  <= '0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      interval_r  <= interval_nxt;
      timeout_r   <= timeout_nxt;
      now_r       <= now_nxt;
      last_chk_r  <= last_chk_nxt;
      busy_r      <= busy_nxt;
      tok_head_r  <= tok_head_nxt;
      pend_v_r    <= pend_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r  <= pend_id_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready      = !busy_r;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign tok_head      = tok_head_r;
  assign timeout_ticks = timeout_r;

  `MTHW_ASSERT_IMP(a_idle_no_token, !busy_r, !tok_tail.v && !tok_head_r.v, "token while idle")
  `MTHW_ASSERT_IMP(a_pend_busy, pend_v_r, busy_r, "pending result while idle")
  `MTHW_ASSERT(a_rep_exit_excl, !(rep.v && tok_tail.v), "report at token exit")
  `MTHW_ASSERT(a_cnt_limit, cnt_r <= CNT_W'(RESULT_LIMIT), "result count over limit")
endmodule

/* design/multi_task_heartbeat_watchdog.sv */
`timescale 1ns / 1ps
// Register, heartbeat and checking ticks: a token walks MAX_TASKS cells, one per cycle
// while results do not stall; ready stays low until the token leaves the last cell, so
// such items do not overlap. A tick without a check leaves ready high. Results leave
// at most one per cycle as the token passes, the token waiting while the output is held;
// the last is presented as the token leaves, and the next item is taken while it waits.
// Synchronous active-low reset clears table valid bits, tick counters, results; limits 5000.
module multi_task_heartbeat_watchdog #(
  parameter int MAX_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mthw_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mthw_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [mthw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mthw_pkg::TICK_W-1:0]    cfg_wdata
);
  import mthw_pkg::*;

  tok_t              chain [0:MAX_TASKS];
  rep_t              reps  [0:MAX_TASKS-1];
  rep_t              rep_all;
  logic              adv;
  logic [TICK_W-1:0] timeout_ticks;

  mthw_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .tok_head      (chain[0]),
    .tok_tail      (chain[MAX_TASKS]),
    .rep           (rep_all),
    .adv           (adv),
    .timeout_ticks (timeout_ticks)
  );

  for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
    mthw_cell u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .adv           (adv),
      .timeout_ticks (timeout_ticks),
      .tok_in        (chain[g]),
      .tok_out       (chain[g+1]),
      .rep           (reps[g])
    );
  end

  // at most one cell reports at a time
  always_comb begin
    rep_all = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      rep_all.v  = rep_all.v | reps[i].v;
      rep_all.id = rep_all.id | (reps[i].id & {ID_W{reps[i].v}});
    end
  end
endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import mthw_pkg::*;

  localparam int TASKS = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE = 20;
  localparam int RAND_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 57;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0] cfg_wdata = '0;

  multi_task_heartbeat_watchdog #(.MAX_TASKS(TASKS)) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog model state
  logic              tbl_valid [TASKS];
  logic [ID_W-1:0]   tbl_id    [TASKS];
  logic [TICK_W-1:0] tbl_stamp [TASKS];
  logic [TICK_W-1:0] tick_now;
  logic [TICK_W-1:0] tick_last_check;
  logic [TICK_W-1:0] interval_cfg;
  logic [TICK_W-1:0] timeout_cfg;
  int unsigned       tbl_used;

  in_item_t    pending_items [$];
  out_item_t   expected_reports [$];
  out_item_t   want;
  logic [ID_W-1:0] id_pool [POOL_SIZE];
  logic [TICK_W-1:0] phase_interval [RAND_PHASES];
  logic [TICK_W-1:0] phase_timeout  [RAND_PHASES];
  int unsigned n_queued = 0;
  int unsigned n_accepted = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          in_taken = 1'b0;
  bit          calm = 1'b0;

  function automatic int find_task(logic [ID_W-1:0] id);
    for (int i = 0; i < TASKS; i++)
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic out_item_t make_report(logic [1:0] kind, logic [ID_W-1:0] id);
    out_item_t r;
    r.report_kind = kind;
    r.report_id = id;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  function automatic void predict_reports(in_item_t it);
    out_item_t batch [$];
    int slot;
    bit any_entry;
    any_entry = 1'b0;
    case (it.action)
      ACT_REGISTER: begin
        slot = find_task(it.task_id);
        if (slot >= 0) begin
          tbl_stamp[slot] = tick_now;
        end else if (tbl_used < TASKS) begin
          tbl_valid[tbl_used] = 1'b1;
          tbl_id[tbl_used] = it.task_id;
          tbl_stamp[tbl_used] = tick_now;
          tbl_used++;
        end else
          batch.push_back(make_report(KIND_DROPPED, it.task_id));
      end
      ACT_HEARTBEAT: begin
        slot = find_task(it.task_id);
        if (slot >= 0) tbl_stamp[slot] = tick_now;
      end
      ACT_TICK: begin
        tick_now = tick_now + 1'b1;
        if (TICK_W'(tick_now - tick_last_check) >= interval_cfg) begin
          for (int i = 0; i < TASKS; i++) begin
            if (tbl_valid[i]) begin
              any_entry = 1'b1;
              if (TICK_W'(tick_now - tbl_stamp[i]) >= timeout_cfg &&
                  batch.size() < RESULT_LIMIT)
                batch.push_back(make_report(KIND_TIMEOUT, tbl_id[i]));
            end
          end
          if (any_entry && batch.size() == 0)
            batch.push_back(make_report(KIND_ALL_OK, '0));
          tick_last_check = tick_now;
        end
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size() - 1].last_of_run = 1'b1;
    foreach (batch[i]) expected_reports.push_back(batch[i]);
  endfunction

  function automatic void send(logic [1:0] action, logic [ID_W-1:0] id);
    in_item_t it;
    it.action = action;
    it.task_id = id;
    pending_items.push_back(it);
    n_queued++;
  endfunction

  function automatic void send_random();
    int unsigned pick;
    logic [ID_W-1:0] id;
    pick = $urandom_range(99);
    id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
    if (pick < 45) send(ACT_TICK, $urandom);
    else if (pick < 75) send(ACT_HEARTBEAT, id);
    else if (pick < 95) send(ACT_REGISTER, id);
    else send(ACT_UNUSED, $urandom);
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TICK_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == CFG_CHECK_INTERVAL) interval_cfg = value;
    else timeout_cfg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait until every transfer is taken and every report is back, then let the scan settle
  task automatic drain();
    @(negedge clk);
    while (n_accepted != n_queued || expected_reports.size() != 0) @(negedge clk);
    repeat (TASKS + 8) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && pending_items.size() > 0 && (calm || $urandom_range(99) >= 8)) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else
        in_valid <= 1'b0;
    end
    out_ready <= calm || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_valid && in_ready) begin
      predict_reports(in_data);
      n_accepted++;
      in_taken = 1'b1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected report: kind %0d id %h last %0d",
                   out_data.report_kind, out_data.report_id, out_data.last_of_run);
      end else begin
        want = expected_reports.pop_front();
        if (want.report_kind != out_data.report_kind ||
            want.report_id != out_data.report_id ||
            want.last_of_run != out_data.last_of_run) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind %0d id %h last %0d, got kind %0d id %h last %0d",
                     want.report_kind, want.report_id, want.last_of_run,
                     out_data.report_kind, out_data.report_id, out_data.last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < TASKS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_id[i] = '0;
      tbl_stamp[i] = '0;
    end
    tick_now = '0;
    tick_last_check = '0;
    tbl_used = 0;
    interval_cfg = DEFAULT_PERIOD;
    timeout_cfg = DEFAULT_PERIOD;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    phase_interval[0] = 3;            phase_timeout[0] = 8;
    phase_interval[1] = 1;            phase_timeout[1] = 32'hFFFF_FFFF;
    phase_interval[2] = 32'hFFFF_FFFF; phase_timeout[2] = 1;
    phase_interval[3] = $urandom_range(6, 1);
    phase_timeout[3] = $urandom_range(20, 1);
    phase_interval[4] = 2;            phase_timeout[4] = 4;
    phase_interval[5] = 1;            phase_timeout[5] = 1;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset intervals: nothing is checked yet, unused code and unknown heartbeat ignored
    send(ACT_UNUSED, '1);
    send(ACT_HEARTBEAT, '1);
    send(ACT_TICK, '1);
    send(ACT_TICK, '0);
    drain();

    // check on an empty table, then an all-ok check with a refreshed entry
    write_reg(CFG_CHECK_INTERVAL, 1);
    send(ACT_TICK, '0);
    send(ACT_REGISTER, '0);
    send(ACT_REGISTER, '1);
    send(ACT_REGISTER, '0);
    send(ACT_TICK, '0);
    drain();

    // zero interval checks on every tick
    write_reg(CFG_CHECK_INTERVAL, 0);
    send(ACT_TICK, '0);
    drain();

    // zero timeout: everything times out
    write_reg(CFG_TIMEOUT, 0);
    send(ACT_TICK, '0);
    send(ACT_HEARTBEAT, '0);
    send(ACT_TICK, '0);
    drain();

    write_reg(CFG_TIMEOUT, 1);
    send(ACT_HEARTBEAT, '0);
    send(ACT_TICK, '0);
    drain();

    write_reg(CFG_TIMEOUT, 3);
    send(ACT_HEARTBEAT, '1);
    send(ACT_TICK, '0);
    send(ACT_TICK, '0);
    send(ACT_TICK, '0);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(CFG_CHECK_INTERVAL, phase_interval[p]);
      write_reg(CFG_TIMEOUT, phase_timeout[p]);
      calm = (p == 4);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_random();
      drain();
    end
    calm = 1'b0;

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
